### rtl/rpr_pkg.sv
// Shared constants and a helper function for the rotary pair rotate block.
package rpr_pkg;

  localparam int unsigned Bf16W = 16;
  localparam int unsigned Fp32W = 32;

  localparam logic [Bf16W-1:0] BF16_CANON_NAN = 16'h7FC0;
  localparam logic [Fp32W-1:0] FP32_QNAN      = 32'h7FC0_0000;
  localparam logic [7:0]       EXP_ALL_ONES   = 8'hFF;

  // Leading zero count of a 32-bit word; 32 for an all-zero word.
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

endpackage

### rtl/rpr_in_if.sv
// Input channel: one bfloat16 pair with its fp32 cosine and sine.
interface rpr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] real_in;
  logic [15:0] imag_in;
  logic [31:0] cos_value;
  logic [31:0] sin_value;

  modport source (output valid, real_in, imag_in, cos_value, sin_value, input ready);
  modport sink   (input valid, real_in, imag_in, cos_value, sin_value, output ready);
endinterface

### rtl/rpr_out_if.sv
// Result channel: rotated bfloat16 pair and the non-finite flag.
interface rpr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] real_out;
  logic [15:0] imag_out;
  logic        non_finite;

  modport source (output valid, real_out, imag_out, non_finite, input ready);
  modport sink   (input valid, real_out, imag_out, non_finite, output ready);
endinterface

### rtl/rpr_mul.sv
// Three-stage bfloat16 by fp32 multiplier, rounded to fp32 (nearest even).
module rpr_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] a_bf16,
  input  logic [31:0] b_fp32,
  output logic [31:0] prod
);

  logic               sgn1_r, sgn1_nxt;
  logic [31:0]        mant1_r, mant1_nxt;
  logic [8:0]         esum1_r, esum1_nxt;
  logic               sgn2_r, sgn2_nxt;
  logic               zero2_r, zero2_nxt;
  logic [31:0]        norm2_r, norm2_nxt;
  logic signed [10:0] be2_r, be2_nxt;
  logic [31:0]        prod_r, prod_nxt;

  // Stage 1: significand product and exponent sum
  always_comb begin
    logic [7:0]  ea, eb, ea_eff, eb_eff;
    logic [7:0]  ma;
    logic [23:0] mb;
    ea        = a_bf16[14:7];
    eb        = b_fp32[30:23];
    ma        = {|ea, a_bf16[6:0]};
    mb        = {|eb, b_fp32[22:0]};
    ea_eff    = (ea == 8'd0) ? 8'd1 : ea;
    eb_eff    = (eb == 8'd0) ? 8'd1 : eb;
    sgn1_nxt  = a_bf16[15] ^ b_fp32[31];
    mant1_nxt = {24'd0, ma} * {8'd0, mb};
    esum1_nxt = {1'b0, ea_eff} + {1'b0, eb_eff};
  end

  // Stage 2: normalise so the leading one sits at bit 31
  always_comb begin
    logic [5:0] lz;
    lz        = rpr_pkg::lzc32(mant1_r);
    sgn2_nxt  = sgn1_r;
    zero2_nxt = (mant1_r == 32'd0);
    norm2_nxt = mant1_r << lz;
    be2_nxt   = $signed({2'b00, esum1_r}) - 11'sd126 - $signed({5'd0, lz});
  end

  // Stage 3: denormalise if needed, round to nearest even, pack
  always_comb begin
    logic signed [10:0] shf;
    logic [5:0]  sh;
    logic [31:0] shifted;
    logic        lost, g, st, inc;
    logic [23:0] m;
    logic [7:0]  exp8;
    logic [30:0] pack;
    shf     = 11'sd1 - be2_r;
    sh      = (be2_r >= 11'sd1) ? 6'd0 : ((shf > 11'sd32) ? 6'd32 : shf[5:0]);
    shifted = norm2_r >> sh;
    lost    = (norm2_r != (shifted << sh));
    exp8    = (be2_r >= 11'sd1) ? be2_r[7:0] : 8'd1;
    m       = shifted[31:8];
    g       = shifted[7];
    st      = (|shifted[6:0]) | lost;
    inc     = g & (st | m[0]);
    pack    = {exp8 - 8'd1, 23'd0} + {7'd0, m} + {30'd0, inc};
    if (zero2_r) begin
      prod_nxt = {sgn2_r, 31'd0};
    end else if (be2_r >= 11'sd255) begin
      prod_nxt = {sgn2_r, rpr_pkg::EXP_ALL_ONES, 23'd0};
    end else begin
      prod_nxt = {sgn2_r, pack};
    end
  end

  // Pipeline registers, all advance together
  always_ff @(posedge clk) begin
    if (en) begin
      sgn1_r  <= sgn1_nxt;
      mant1_r <= mant1_nxt;
      esum1_r <= esum1_nxt;
      sgn2_r  <= sgn2_nxt;
      zero2_r <= zero2_nxt;
      norm2_r <= norm2_nxt;
      be2_r   <= be2_nxt;
      prod_r  <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/rpr_add.sv
// Three-stage fp32 adder/subtractor, round to nearest even, gradual underflow.
module rpr_add (
  input  logic        clk,
  input  logic        en,
  input  logic        sub,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] sum
);

  logic        nan1_r, nan1_nxt, inf1_r, inf1_nxt, isgn1_r, isgn1_nxt;
  logic        sx1_r, sx1_nxt, op1_r, op1_nxt;
  logic [7:0]  ex1_r, ex1_nxt;
  logic [26:0] xs1_r, xs1_nxt, ys1_r, ys1_nxt;
  logic        nan2_r, nan2_nxt, inf2_r, inf2_nxt, isgn2_r, isgn2_nxt;
  logic        sx2_r, sx2_nxt, op2_r, op2_nxt, zero2_r, zero2_nxt;
  logic [7:0]  ex2_r, ex2_nxt;
  logic [27:0] r2_r, r2_nxt;
  logic [5:0]  lz2_r, lz2_nxt;
  logic [31:0] sum_r, sum_nxt;

  // Stage 1: specials, order by magnitude, align the smaller operand
  always_comb begin
    logic        sb, inf_a, inf_b, swap, sy;
    logic [30:0] xm, ym;
    logic [7:0]  ey, exe, eye, d;
    logic [4:0]  dd;
    logic [26:0] yv, ysh;
    sb     = b[31] ^ sub;
    inf_a  = (a[30:23] == rpr_pkg::EXP_ALL_ONES);
    inf_b  = (b[30:23] == rpr_pkg::EXP_ALL_ONES);
    nan1_nxt  = inf_a & inf_b & (a[31] != sb);
    inf1_nxt  = inf_a | inf_b;
    isgn1_nxt = inf_a ? a[31] : sb;
    swap   = (b[30:0] > a[30:0]);
    xm     = swap ? b[30:0] : a[30:0];
    ym     = swap ? a[30:0] : b[30:0];
    sx1_nxt = swap ? sb : a[31];
    sy     = swap ? a[31] : sb;
    op1_nxt = sx1_nxt ^ sy;
    ey     = ym[30:23];
    exe    = (xm[30:23] == 8'd0) ? 8'd1 : xm[30:23];
    eye    = (ey == 8'd0) ? 8'd1 : ey;
    d      = exe - eye;
    dd     = (d > 8'd27) ? 5'd27 : d[4:0];
    yv     = {|ey, ym[22:0], 3'b000};
    ysh    = yv >> dd;
    ys1_nxt = {ysh[26:1], ysh[0] | (yv != (ysh << dd))};
    xs1_nxt = {|xm[30:23], xm[22:0], 3'b000};
    ex1_nxt = exe;
  end

  // Stage 2: add or subtract magnitudes, count leading zeros
  always_comb begin
    r2_nxt    = op1_r ? ({1'b0, xs1_r} - {1'b0, ys1_r}) : ({1'b0, xs1_r} + {1'b0, ys1_r});
    lz2_nxt   = rpr_pkg::lzc32({r2_nxt, 4'b0000});
    zero2_nxt = (r2_nxt == 28'd0);
    nan2_nxt  = nan1_r;
    inf2_nxt  = inf1_r;
    isgn2_nxt = isgn1_r;
    sx2_nxt   = sx1_r;
    op2_nxt   = op1_r;
    ex2_nxt   = ex1_r;
  end

  // Stage 3: normalise, round to nearest even, pack
  always_comb begin
    logic [26:0] m27;
    logic [8:0]  exp9;
    logic [5:0]  lzm1, sh;
    logic [23:0] m;
    logic        g, st, inc;
    logic [30:0] pack;
    lzm1 = lz2_r - 6'd1;
    sh   = (lzm1 > {1'b0, ex2_r[4:0]} - 6'd1 || ex2_r > 8'd31) ?
           ((ex2_r > 8'd31) ? lzm1 : ({1'b0, ex2_r[4:0]} - 6'd1)) : lzm1;
    if (r2_r[27]) begin
      m27  = {r2_r[27:2], r2_r[1] | r2_r[0]};
      exp9 = {1'b0, ex2_r} + 9'd1;
    end else begin
      m27  = r2_r[26:0] << sh;
      exp9 = {1'b0, ex2_r} - {3'd0, sh};
    end
    m    = m27[26:3];
    g    = m27[2];
    st   = |m27[1:0];
    inc  = g & (st | m[0]);
    pack = {exp9[7:0] - 8'd1, 23'd0} + {7'd0, m} + {30'd0, inc};
    if (nan2_r) begin
      sum_nxt = rpr_pkg::FP32_QNAN;
    end else if (inf2_r) begin
      sum_nxt = {isgn2_r, rpr_pkg::EXP_ALL_ONES, 23'd0};
    end else if (zero2_r) begin
      sum_nxt = {sx2_r & ~op2_r, 31'd0};
    end else if (exp9 >= 9'd255) begin
      sum_nxt = {sx2_r, rpr_pkg::EXP_ALL_ONES, 23'd0};
    end else begin
      sum_nxt = {sx2_r, pack};
    end
  end

  // Pipeline registers, all advance together
  always_ff @(posedge clk) begin
    if (en) begin
      nan1_r  <= nan1_nxt;
      inf1_r  <= inf1_nxt;
      isgn1_r <= isgn1_nxt;
      sx1_r   <= sx1_nxt;
      op1_r   <= op1_nxt;
      ex1_r   <= ex1_nxt;
      xs1_r   <= xs1_nxt;
      ys1_r   <= ys1_nxt;
      nan2_r  <= nan2_nxt;
      inf2_r  <= inf2_nxt;
      isgn2_r <= isgn2_nxt;
      sx2_r   <= sx2_nxt;
      op2_r   <= op2_nxt;
      zero2_r <= zero2_nxt;
      ex2_r   <= ex2_nxt;
      r2_r    <= r2_nxt;
      lz2_r   <= lz2_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

### rtl/rotary_pair_rotate_core.sv
// Throughput: one word per cycle; the pipeline stalls as a whole while the
// output word is held, so in_if.ready follows out_if.ready in that case.
// Stages: 3 for the fp32 products, 3 for the fp32 add/sub, 1 for bf16 rounding.
// Reset (rst_n low, synchronous) empties the pipeline and clears the
// inverse rotation register; data registers are not reset.
module rotary_pair_rotate_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  rpr_in_if.sink       in_if,
  rpr_out_if.source    out_if
);

  localparam int unsigned Depth = 6;

  logic             inv_r;
  logic             en;
  logic [Depth-1:0] vld_r;
  logic [Depth-1:0] nf_r;
  logic             nf_nxt;
  logic [31:0]      sin_eff;
  logic [31:0]      p_rc, p_is, p_rs, p_ic, r_sum, i_sum;
  logic             out_vld_r;
  logic [15:0]      real_out_r, imag_out_r;
  logic             nf_out_r;

  // fp32 to bf16, round to nearest even, NaN made canonical
  function automatic logic [15:0] to_bf16(input logic [31:0] u);
    logic [31:0] t;
    t = u + 32'h0000_7FFF + {31'd0, u[16]};
    if (u[30:23] == rpr_pkg::EXP_ALL_ONES && u[22:0] != 23'd0) begin
      return rpr_pkg::BF16_CANON_NAN;
    end
    return t[31:16];
  endfunction

  // whole pipeline moves unless a finished word is held
  assign en          = ~out_vld_r | out_if.ready;
  assign in_if.ready = en;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (cfg_we) begin
      inv_r <= cfg_wdata;
    end
  end

  assign sin_eff = {in_if.sin_value[31] ^ inv_r, in_if.sin_value[30:0]};

  // any non-finite operand flags the word
  assign nf_nxt = (in_if.real_in[14:7] == rpr_pkg::EXP_ALL_ONES) |
                  (in_if.imag_in[14:7] == rpr_pkg::EXP_ALL_ONES) |
                  (in_if.cos_value[30:23] == rpr_pkg::EXP_ALL_ONES) |
                  (sin_eff[30:23] == rpr_pkg::EXP_ALL_ONES);

  rpr_mul u_mul_rc (.clk, .en, .a_bf16(in_if.real_in), .b_fp32(in_if.cos_value), .prod(p_rc));
  rpr_mul u_mul_is (.clk, .en, .a_bf16(in_if.imag_in), .b_fp32(sin_eff),         .prod(p_is));
  rpr_mul u_mul_rs (.clk, .en, .a_bf16(in_if.real_in), .b_fp32(sin_eff),         .prod(p_rs));
  rpr_mul u_mul_ic (.clk, .en, .a_bf16(in_if.imag_in), .b_fp32(in_if.cos_value), .prod(p_ic));

  rpr_add u_add_re (.clk, .en, .sub(1'b1), .a(p_rc), .b(p_is), .sum(r_sum));
  rpr_add u_add_im (.clk, .en, .sub(1'b0), .a(p_rs), .b(p_ic), .sum(i_sum));

  // valid and flag bits travel beside the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[Depth-2:0], in_if.valid};
      out_vld_r <= vld_r[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nf_r       <= {nf_r[Depth-2:0], nf_nxt};
      nf_out_r   <= nf_r[Depth-1];
      real_out_r <= nf_r[Depth-1] ? 16'd0 : to_bf16(r_sum);
      imag_out_r <= nf_r[Depth-1] ? 16'd0 : to_bf16(i_sum);
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.real_out   = real_out_r;
  assign out_if.imag_out   = imag_out_r;
  assign out_if.non_finite = nf_out_r;

`ifndef ASSERT_OFF
  // flagged words carry zero data
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && nf_out_r |-> real_out_r == 16'd0 && imag_out_r == 16'd0)
    else $error("non-finite word with non-zero data");
  // a held output word blocks the input side
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_if.ready |-> !in_if.ready)
    else $error("input taken while output stalled");
  // an empty output stage never blocks the input
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_if.ready)
    else $error("input blocked with empty output");
  // a word leaving the last stage reaches the output register
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[Depth-1] |=> out_vld_r)
    else $error("word lost at output stage");
`endif

endmodule
